// ----- rtl/core/tbc_pkg.sv -----
package tbc_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int MAX_COLS = 1024;

    localparam int PIX_W = 8;
    localparam int THR_W = 9;
    localparam int IDX_W = 10;
    localparam int AREA_W = 21;
    localparam int SUM_W = 30;
    localparam int CENTER_W = 10;
    localparam int IDX_CMP_W = 13;
    localparam int QUEUE_DEPTH = 2;
    localparam int STEP_W = $clog2(CENTER_W + 1);

    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(128);
    localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CENTER_W-1:0] CENTER_MAX = {CENTER_W{1'b1}};
    localparam logic [IDX_CMP_W-1:0] ROW_LIMIT = IDX_CMP_W'(MAX_ROWS);
    localparam logic [IDX_CMP_W-1:0] COL_LIMIT = IDX_CMP_W'(MAX_COLS);

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
        logic             frame_last;
    } pixel_item_t;

    typedef struct packed {
        logic [AREA_W-1:0]   object_area;
        logic [CENTER_W-1:0] row_center;
        logic [CENTER_W-1:0] col_center;
        logic                empty_frame;
    } result_item_t;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [SUM_W-1:0]  row_sum;
        logic [SUM_W-1:0]  col_sum;
    } frame_sums_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

// ----- rtl/core/tbc_front.sv -----
module tbc_front
    import tbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              threshold_wr_en,
    input  logic [THR_W-1:0]  threshold_wr_data,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  pixel_item_t       pixel,
    input  queue_status_t     queue_status,
    output logic              push,
    output frame_sums_t       push_data
);

    logic [THR_W-1:0]  threshold_reg;
    logic [AREA_W-1:0] area_reg;
    logic [AREA_W-1:0] area_next;
    logic [SUM_W-1:0]  row_sum_reg;
    logic [SUM_W-1:0]  row_sum_next;
    logic [SUM_W-1:0]  col_sum_reg;
    logic [SUM_W-1:0]  col_sum_next;
    logic [SUM_W:0]    row_add;
    logic [SUM_W:0]    col_add;
    logic              accept;
    logic              in_frame;
    logic              is_object;
    frame_sums_t       counted;

    assign pixel_stall = queue_status.full;
    assign accept = pixel_valid && !queue_status.full;

    assign in_frame = ({{(IDX_CMP_W - IDX_W){1'b0}}, pixel.row_index} < ROW_LIMIT) &&
                      ({{(IDX_CMP_W - IDX_W){1'b0}}, pixel.col_index} < COL_LIMIT);
    assign is_object = in_frame && ({1'b0, pixel.pixel_value} >= threshold_reg);

    assign row_add = {1'b0, row_sum_reg} + (SUM_W + 1)'(pixel.row_index);
    assign col_add = {1'b0, col_sum_reg} + (SUM_W + 1)'(pixel.col_index);

    always_comb
    begin
        counted.area = area_reg;
        counted.row_sum = row_sum_reg;
        counted.col_sum = col_sum_reg;
        if (is_object)
        begin
            counted.area = (area_reg == AREA_MAX) ? AREA_MAX : area_reg + AREA_W'(1);
            counted.row_sum = row_add[SUM_W] ? SUM_MAX : row_add[SUM_W-1:0];
            counted.col_sum = col_add[SUM_W] ? SUM_MAX : col_add[SUM_W-1:0];
        end
    end

    always_comb
    begin
        area_next = area_reg;
        row_sum_next = row_sum_reg;
        col_sum_next = col_sum_reg;
        if (accept)
        begin
            if (pixel.frame_last)
            begin
                area_next = '0;
                row_sum_next = '0;
                col_sum_next = '0;
            end
            else
            begin
                area_next = counted.area;
                row_sum_next = counted.row_sum;
                col_sum_next = counted.col_sum;
            end
        end
    end

    assign push = accept && pixel.frame_last;
    assign push_data = counted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            area_reg <= '0;
            row_sum_reg <= '0;
            col_sum_reg <= '0;
        end
        else
        begin
            if (threshold_wr_en)
            begin
                threshold_reg <= threshold_wr_data;
            end
            area_reg <= area_next;
            row_sum_reg <= row_sum_next;
            col_sum_reg <= col_sum_next;
        end
    end

endmodule

// ----- rtl/core/tbc_queue.sv -----
module tbc_queue
    import tbc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  frame_sums_t   push_data,
    input  logic          pop,
    output frame_sums_t   head,
    output queue_status_t status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_sums_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign status.full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop = pop && !status.empty;
    assign head = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/tbc_back.sv -----
module tbc_back
    import tbc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t queue_status,
    input  frame_sums_t   head,
    output logic          pop,
    output logic          result_valid,
    input  logic          result_stall,
    output result_item_t  result
);

    localparam int REM_W = AREA_W;

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;
    logic [AREA_W-1:0]    area_reg;
    logic [REM_W-1:0]     row_rem_reg;
    logic [REM_W-1:0]     col_rem_reg;
    logic [CENTER_W-1:0]  row_low_reg;
    logic [CENTER_W-1:0]  col_low_reg;
    logic [CENTER_W-1:0]  row_quo_reg;
    logic [CENTER_W-1:0]  col_quo_reg;
    logic                 row_ovf_reg;
    logic                 col_ovf_reg;
    logic                 out_valid_reg;
    result_item_t         out_reg;
    logic                 step_en;
    logic                 load_out;
    logic                 out_free;
    logic                 last_step;
    logic [REM_W:0]       row_trial;
    logic [REM_W:0]       col_trial;
    logic                 row_ge;
    logic                 col_ge;
    logic [REM_W-1:0]     head_row_hi;
    logic [REM_W-1:0]     head_col_hi;
    logic                 frame_empty;

    assign out_free = !out_valid_reg || !result_stall;
    assign last_step = (step_reg == STEP_W'(CENTER_W - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!queue_status.empty)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (last_step)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop = 1'b0;
        step_en = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                pop = !queue_status.empty;
            end
            BK_DIV:
            begin
                step_en = 1'b1;
            end
            BK_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign step_next = step_en ? (last_step ? '0 : step_reg + STEP_W'(1)) : '0;

    assign head_row_hi = REM_W'(head.row_sum[SUM_W-1:CENTER_W]);
    assign head_col_hi = REM_W'(head.col_sum[SUM_W-1:CENTER_W]);

    assign row_trial = {row_rem_reg, row_low_reg[CENTER_W-1]};
    assign col_trial = {col_rem_reg, col_low_reg[CENTER_W-1]};
    assign row_ge = row_trial >= {1'b0, area_reg};
    assign col_ge = col_trial >= {1'b0, area_reg};

    assign frame_empty = (area_reg == '0);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            area_reg <= head.area;
            row_rem_reg <= head_row_hi;
            col_rem_reg <= head_col_hi;
            row_low_reg <= head.row_sum[CENTER_W-1:0];
            col_low_reg <= head.col_sum[CENTER_W-1:0];
            row_ovf_reg <= head_row_hi >= head.area;
            col_ovf_reg <= head_col_hi >= head.area;
        end
        else if (step_en)
        begin
            row_rem_reg <= row_ge ? REM_W'(row_trial - {1'b0, area_reg}) : REM_W'(row_trial);
            col_rem_reg <= col_ge ? REM_W'(col_trial - {1'b0, area_reg}) : REM_W'(col_trial);
            row_low_reg <= {row_low_reg[CENTER_W-2:0], 1'b0};
            col_low_reg <= {col_low_reg[CENTER_W-2:0], 1'b0};
            row_quo_reg <= {row_quo_reg[CENTER_W-2:0], row_ge};
            col_quo_reg <= {col_quo_reg[CENTER_W-2:0], col_ge};
        end
        if (load_out)
        begin
            out_reg.object_area <= area_reg;
            out_reg.empty_frame <= frame_empty;
            out_reg.row_center <= frame_empty ? '0 : (row_ovf_reg ? CENTER_MAX : row_quo_reg);
            out_reg.col_center <= frame_empty ? '0 : (col_ovf_reg ? CENTER_MAX : col_quo_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            step_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result = out_reg;

endmodule

// ----- rtl/core/threshold_blob_centroid.sv -----
// Thresholded blob centroid: takes one pixel per cycle, counts pixels at or above the
// threshold and sums their row and column, and on the item marked frame_last gives one
// result with the area and the truncated mean row and column (zero centers and
// empty_frame set when no pixel qualified). Pixels stream in at one per cycle while
// pixel_stall is low; frame totals go into a two-entry queue, and the back end takes
// the totals of one frame from it, lets a shared-step divider produce both centers and
// then loads the output register, taking the next frame only after that load.
// pixel_stall rises only when frame totals fill the queue, as short frames or a stalled
// result side can cause. The threshold may be written only while no frame is in flight.
module threshold_blob_centroid
    import tbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              threshold_wr_en,
    input  logic [THR_W-1:0]  threshold_wr_data,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  pixel_item_t       pixel,
    output logic              result_valid,
    input  logic              result_stall,
    output result_item_t      result
);

    queue_status_t queue_status;
    logic          push;
    logic          pop;
    frame_sums_t   push_data;
    frame_sums_t   head;

    tbc_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .threshold_wr_en   (threshold_wr_en),
        .threshold_wr_data (threshold_wr_data),
        .pixel_valid       (pixel_valid),
        .pixel_stall       (pixel_stall),
        .pixel             (pixel),
        .queue_status      (queue_status),
        .push              (push),
        .push_data         (push_data)
    );

    tbc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (queue_status)
    );

    tbc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_status (queue_status),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && queue_status.full))
        else $error("Frame totals pushed into a full queue.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.empty_frame == (result.object_area == '0)))
        else $error("Empty flag disagrees with the area.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.empty_frame) |->
            (result.row_center == '0 && result.col_center == '0))
        else $error("Empty frame with nonzero centers.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && queue_status.empty) == 1'b0)
        else $error("Back end popped an empty queue.");

endmodule
